### rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

   localparam int OperandWidthDefault = 32;

endpackage

`default_nettype wire

### rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply modular exponentiation over a bit-serial multiplier.
// ----------------------------------------------------------------------------
// One transaction at a time is computed. The base is first reduced with one
// pass of the shared bit-serial multiplier, then each exponent bit, most
// significant first, costs a squaring and, when set, one more multiply. A zero
// exponent or modulus skips the multiplier. The result sits in an output
// register, so a new transaction is taken while the previous result still waits.
`default_nettype none

module modular_exponentiation #(
   parameter int OPERAND_WIDTH = mexp_pkg::OperandWidthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OPERAND_WIDTH-1:0] req_base_value,
   input  wire logic [OPERAND_WIDTH-1:0] req_exponent_value,
   input  wire logic [OPERAND_WIDTH-1:0] req_modulus_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [OPERAND_WIDTH-1:0]      rsp_power_result
);
   import mexp_pkg::*;

   localparam int CntWidth = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StBase   = 3'd1;
   localparam logic [2:0] StSquare = 3'd2;
   localparam logic [2:0] StMult   = 3'd3;
   localparam logic [2:0] StPush   = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [OPERAND_WIDTH-1:0] expo_sr_ff, expo_sr_in;
   logic [CntWidth-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic [OPERAND_WIDTH-1:0] base_ff, base_in;
   logic [OPERAND_WIDTH-1:0] modu_ff, modu_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OPERAND_WIDTH-1:0] rsp_result_ff, rsp_result_in;

   logic                     mul_start;
   logic [OPERAND_WIDTH-1:0] mul_a, mul_b, mul_m;
   logic                     mul_done;
   logic [OPERAND_WIDTH-1:0] mul_product;
   logic [OPERAND_WIDTH-1:0] one_mod;
   logic                     req_take, rsp_free;

   assign req_stall = (state_ff != StIdle);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign one_mod   = (req_modulus_value == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);

   mexp_modmul #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .mul_m   (mul_m),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      state_in      = state_ff;
      expo_sr_in    = expo_sr_ff;
      bit_cnt_in    = bit_cnt_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      modu_in       = modu_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_result_in = rsp_result_ff;
      mul_start     = 1'b0;
      mul_a         = mul_product;
      mul_b         = mul_product;
      mul_m         = modu_ff;

      unique case (state_ff)
         StIdle: begin
            if (req_take) begin
               expo_sr_in = req_exponent_value;
               modu_in    = req_modulus_value;
               bit_cnt_in = CntWidth'(OPERAND_WIDTH - 1);
               if (req_exponent_value == '0) begin
                  acc_in   = OPERAND_WIDTH'(1);
                  state_in = StPush;
               end else if (req_modulus_value == '0) begin
                  acc_in   = '0;
                  state_in = StPush;
               end else begin
                  acc_in    = one_mod;
                  mul_start = 1'b1;
                  mul_a     = one_mod;
                  mul_b     = req_base_value;
                  mul_m     = req_modulus_value;
                  state_in  = StBase;
               end
            end
         end
         StBase: begin
            if (mul_done) begin
               base_in   = mul_product;
               mul_start = 1'b1;
               mul_a     = acc_ff;
               mul_b     = acc_ff;
               state_in  = StSquare;
            end
         end
         StSquare, StMult: begin
            if (mul_done) begin
               acc_in = mul_product;
               if (state_ff == StSquare && expo_sr_ff[OPERAND_WIDTH-1]) begin
                  mul_start = 1'b1;
                  mul_b     = base_ff;
                  state_in  = StMult;
               end else if (bit_cnt_ff == '0) begin
                  state_in = StPush;
               end else begin
                  bit_cnt_in = bit_cnt_ff - CntWidth'(1);
                  expo_sr_in = expo_sr_ff << 1;
                  mul_start  = 1'b1;
                  state_in   = StSquare;
               end
            end
         end
         StPush: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = acc_ff;
               state_in      = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      expo_sr_ff    <= expo_sr_in;
      bit_cnt_ff    <= bit_cnt_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
      modu_ff       <= modu_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;

endmodule

`default_nettype wire

### rtl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: one multiplier bit per cycle, most
// significant first, with a doubling and a conditional add, each reduced.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modmul #(
   parameter int OPERAND_WIDTH = mexp_pkg::OperandWidthDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [OPERAND_WIDTH-1:0] mul_a,
   input  wire logic [OPERAND_WIDTH-1:0] mul_b,
   input  wire logic [OPERAND_WIDTH-1:0] mul_m,
   output logic                          done,
   output logic [OPERAND_WIDTH-1:0]      product
);
   import mexp_pkg::*;

   localparam int CntWidth = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;
   localparam logic [CntWidth-1:0] LastCount = CntWidth'(OPERAND_WIDTH - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CntWidth-1:0]      cnt_ff, cnt_in;
   logic [OPERAND_WIDTH-1:0] acc_ff, acc_in;
   logic [OPERAND_WIDTH-1:0] a_ff, a_in;
   logic [OPERAND_WIDTH-1:0] b_sr_ff, b_sr_in;
   logic [OPERAND_WIDTH-1:0] m_ff, m_in;
   logic [OPERAND_WIDTH:0]   dbl, dbl_red, sum, sum_red;

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? dbl - {1'b0, m_ff} : dbl;
      sum     = dbl_red + (b_sr_ff[OPERAND_WIDTH-1] ? {1'b0, a_ff} : '0);
      sum_red = (sum >= {1'b0, m_ff}) ? sum - {1'b0, m_ff} : sum;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_sr_in = b_sr_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         acc_in  = '0;
         a_in    = mul_a;
         b_sr_in = mul_b;
         m_in    = mul_m;
      end else if (busy_ff) begin
         acc_in  = sum_red[OPERAND_WIDTH-1:0];
         b_sr_in = b_sr_ff << 1;
         cnt_in  = cnt_ff + CntWidth'(1);
         if (cnt_ff == LastCount) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      a_ff    <= a_in;
      b_sr_ff <= b_sr_in;
      m_ff    <= m_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire
